[rtl/core/modular_inverse_top_defines.svh]
// Assertion macros used by the modular inverse checker.
// No dependencies; take in with `include before the module header.
`ifndef MODULAR_INVERSE_TOP_DEFINES_SVH
`define MODULAR_INVERSE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define MI_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("modular inverse check failed");

// Next-cycle implication, disabled while reset is low.
`define MI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("modular inverse check failed");

`endif

[rtl/core/mi_pkg.sv]
// Types, constants and the microcode table of the modular inverse block.
// No dependencies.
package mi_pkg;

    localparam int MOD_W  = 31;  // modulus, inverse and Euclid remainders
    localparam int TW     = 33;  // signed Bezout coefficients
    localparam int STEP_W = 4;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_DIV_MAG,
        OP_RESIDUE,
        OP_DIV_R,
        OP_MUL,
        OP_TUPD,
        OP_FIX,
        OP_EMIT_OK,
        OP_EMIT_FAIL
    } t_mi_op;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_INPUT,
        COND_MOD_ZERO,
        COND_DIV_BUSY,
        COND_NR_ZERO,
        COND_GCD_BIG,
        COND_OUT_FULL
    } t_mi_cond;

    typedef struct packed {
        t_mi_op              op;
        t_mi_cond            cond;
        logic [STEP_W-1:0]   target;
    } t_mi_uword;

    typedef struct packed {
        logic in_valid;
        logic mod_zero;
        logic div_busy;
        logic nr_zero;
        logic gcd_big;
        logic out_full;
    } t_mi_status;

    localparam logic [STEP_W-1:0] S_IDLE     = 4'd0;
    localparam logic [STEP_W-1:0] S_CHKMOD   = 4'd1;
    localparam logic [STEP_W-1:0] S_RDIV     = 4'd2;
    localparam logic [STEP_W-1:0] S_RWAIT    = 4'd3;
    localparam logic [STEP_W-1:0] S_RESIDUE  = 4'd4;
    localparam logic [STEP_W-1:0] S_LOOP     = 4'd5;
    localparam logic [STEP_W-1:0] S_EWAIT    = 4'd6;
    localparam logic [STEP_W-1:0] S_MUL      = 4'd7;
    localparam logic [STEP_W-1:0] S_TUPD     = 4'd8;
    localparam logic [STEP_W-1:0] S_DONE     = 4'd9;
    localparam logic [STEP_W-1:0] S_FIX      = 4'd10;
    localparam logic [STEP_W-1:0] S_OK_WAIT  = 4'd11;
    localparam logic [STEP_W-1:0] S_OK_EMIT  = 4'd12;
    localparam logic [STEP_W-1:0] S_FAIL     = 4'd13;
    localparam logic [STEP_W-1:0] S_FAIL_EMIT = 4'd14;

    // Jump to target when the condition holds, else fall through to the next step.
    function automatic t_mi_uword mi_ucode(input logic [STEP_W-1:0] step);
        t_mi_uword w;
        unique case (step)
            S_IDLE:      w = '{OP_LOAD,      COND_NO_INPUT, S_IDLE};
            S_CHKMOD:    w = '{OP_NOP,       COND_MOD_ZERO, S_FAIL};
            S_RDIV:      w = '{OP_DIV_MAG,   COND_NEVER,    S_IDLE};
            S_RWAIT:     w = '{OP_NOP,       COND_DIV_BUSY, S_RWAIT};
            S_RESIDUE:   w = '{OP_RESIDUE,   COND_NEVER,    S_IDLE};
            S_LOOP:      w = '{OP_DIV_R,     COND_NR_ZERO,  S_DONE};
            S_EWAIT:     w = '{OP_NOP,       COND_DIV_BUSY, S_EWAIT};
            S_MUL:       w = '{OP_MUL,       COND_NEVER,    S_IDLE};
            S_TUPD:      w = '{OP_TUPD,      COND_ALWAYS,   S_LOOP};
            S_DONE:      w = '{OP_NOP,       COND_GCD_BIG,  S_FAIL};
            S_FIX:       w = '{OP_FIX,       COND_NEVER,    S_IDLE};
            S_OK_WAIT:   w = '{OP_NOP,       COND_OUT_FULL, S_OK_WAIT};
            S_OK_EMIT:   w = '{OP_EMIT_OK,   COND_ALWAYS,   S_IDLE};
            S_FAIL:      w = '{OP_NOP,       COND_OUT_FULL, S_FAIL};
            S_FAIL_EMIT: w = '{OP_EMIT_FAIL, COND_ALWAYS,   S_IDLE};
            default:     w = '{OP_NOP,       COND_ALWAYS,   S_IDLE};
        endcase
        return w;
    endfunction

endpackage

[rtl/core/mi_if.sv]
// Input and output word channels of the modular inverse block.
// Depends on mi_pkg.
interface mi_in_if #(
    parameter int VALUE_WIDTH = 32
) ();
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface mi_out_if import mi_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [MOD_W-1:0] inverse;
    logic             no_inverse;

    modport source (output valid, output inverse, output no_inverse, input ready);
    modport sink   (input valid, input inverse, input no_inverse, output ready);
endinterface

[rtl/core/modular_inverse_top.sv]
// Modular inverse by extended Euclid, run by a microcoded sequencer over one bit-serial divider.
// Each word makes one divider pass for its residue and one per Euclid step, so the
// divider loop sets the pace. A new word is taken in only once the result of the last
// word is in the output register.
// A result word waits in an output register while the next word is taken in.
// Reset (synchronous, active low) clears the sequencer and output valid; modulus resets to 1.
module modular_inverse_top import mi_pkg::*; #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [MOD_W-1:0] i_cfg_wdata,
    mi_in_if.sink            i_in,
    mi_out_if.source         o_out
);
    localparam int DW = (VALUE_WIDTH > MOD_W) ? VALUE_WIDTH : MOD_W;

    t_mi_op           w_op;
    t_mi_status       w_status;
    logic             w_div_start;
    logic             w_div_busy;
    logic [DW-1:0]    w_dividend;
    logic [MOD_W-1:0] w_divisor;
    logic [DW-1:0]    w_quot;
    logic [MOD_W-1:0] w_rem;

    mi_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_op     (w_op)
    );

    mi_divider #(.DW(DW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_busy     (w_div_busy),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    mi_datapath #(.VALUE_WIDTH(VALUE_WIDTH), .DW(DW)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_op           (w_op),
        .i_div_busy     (w_div_busy),
        .i_div_quot     (w_quot),
        .i_div_rem      (w_rem),
        .o_div_start    (w_div_start),
        .o_div_dividend (w_dividend),
        .o_div_divisor  (w_divisor),
        .o_status       (w_status),
        .i_in           (i_in),
        .o_out          (o_out)
    );
endmodule

[rtl/core/mi_divider.sv]
// Restoring bit-serial divider, one quotient bit a cycle, shared by all divisions.
// Depends on mi_pkg.
module mi_divider import mi_pkg::*; #(
    parameter int DW = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DW-1:0]    i_dividend,
    input  logic [MOD_W-1:0] i_divisor,
    output logic             o_busy,
    output logic [DW-1:0]    o_quot,
    output logic [MOD_W-1:0] o_rem
);
    localparam int CW = $clog2(DW + 1);

    logic             r_busy;
    logic [CW-1:0]    r_cnt;
    logic [DW-1:0]    r_quo;
    logic [MOD_W-1:0] r_rem;
    logic [MOD_W-1:0] r_dvs;
    logic [MOD_W:0]   w_trial;
    logic             w_ge;

    assign w_trial = {r_rem, r_quo[DW-1]};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(DW);
        end else if (r_busy) begin
            r_busy <= (r_cnt != CW'(1));
            r_cnt  <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DW-2:0], w_ge};
            r_rem <= w_ge ? MOD_W'(w_trial - {1'b0, r_dvs}) : w_trial[MOD_W-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;
endmodule

[rtl/core/mi_seq.sv]
// Microcode sequencer: step counter, control table and conditional jumps.
// Depends on mi_pkg.
module mi_seq import mi_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_mi_status i_status,
    output t_mi_op     o_op
);
    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    t_mi_uword         w_uword;
    logic              w_take;

    assign w_uword = mi_ucode(r_step);

    always_comb begin
        unique case (w_uword.cond)
            COND_NEVER:    w_take = 1'b0;
            COND_ALWAYS:   w_take = 1'b1;
            COND_NO_INPUT: w_take = !i_status.in_valid;
            COND_MOD_ZERO: w_take = i_status.mod_zero;
            COND_DIV_BUSY: w_take = i_status.div_busy;
            COND_NR_ZERO:  w_take = i_status.nr_zero;
            COND_GCD_BIG:  w_take = i_status.gcd_big;
            COND_OUT_FULL: w_take = i_status.out_full;
            default:       w_take = 1'b1;
        endcase
        n_step = w_take ? w_uword.target : r_step + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_op = w_uword.op;
endmodule

[rtl/core/mi_datapath.sv]
// Datapath: modulus register, Euclid remainders, Bezout coefficients, output word.
// Depends on mi_pkg and the channel interfaces in mi_if.
module mi_datapath import mi_pkg::*; #(
    parameter int VALUE_WIDTH = 32,
    parameter int DW          = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [MOD_W-1:0] i_cfg_wdata,
    input  t_mi_op           i_op,
    input  logic             i_div_busy,
    input  logic [DW-1:0]    i_div_quot,
    input  logic [MOD_W-1:0] i_div_rem,
    output logic             o_div_start,
    output logic [DW-1:0]    o_div_dividend,
    output logic [MOD_W-1:0] o_div_divisor,
    output t_mi_status       o_status,
    mi_in_if.sink            i_in,
    mi_out_if.source         o_out
);
    logic [MOD_W-1:0]       r_modulus;
    logic                   r_neg;
    logic [DW-1:0]          r_mag;
    logic [MOD_W-1:0]       r_r;
    logic [MOD_W-1:0]       r_nr;
    logic signed [TW-1:0]   r_t;
    logic signed [TW-1:0]   r_nt;
    logic signed [TW-1:0]   r_prod;
    logic                   r_out_valid;
    logic [MOD_W-1:0]       r_out_inverse;
    logic                   r_out_flag;
    logic [VALUE_WIDTH-1:0] w_mag;
    logic signed [TW-1:0]   w_q;
    logic signed [TW-1:0]   w_m;

    assign w_mag = i_in.value[VALUE_WIDTH-1] ? (~i_in.value + 1'b1) : i_in.value;
    assign w_q   = $signed({{(TW-MOD_W){1'b0}}, i_div_quot[MOD_W-1:0]});
    assign w_m   = $signed({{(TW-MOD_W){1'b0}}, r_modulus});

    assign i_in.ready     = (i_op == OP_LOAD);
    assign o_div_start    = (i_op == OP_DIV_MAG) || (i_op == OP_DIV_R);
    assign o_div_dividend = (i_op == OP_DIV_MAG) ? r_mag : DW'(r_r);
    assign o_div_divisor  = (i_op == OP_DIV_MAG) ? r_modulus : r_nr;

    assign o_status.in_valid = i_in.valid;
    assign o_status.mod_zero = (r_modulus == '0);
    assign o_status.div_busy = i_div_busy;
    assign o_status.nr_zero  = (r_nr == '0);
    assign o_status.gcd_big  = (r_r > MOD_W'(1));
    assign o_status.out_full = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus   <= MOD_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_modulus <= i_cfg_wdata;
            end
            // emit only happens with the slot free, so set and drain never collide
            if ((i_op == OP_EMIT_OK) || (i_op == OP_EMIT_FAIL)) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_op)
            OP_LOAD: begin
                if (i_in.valid) begin
                    r_neg <= i_in.value[VALUE_WIDTH-1];
                    r_mag <= DW'(w_mag);
                end
            end
            OP_RESIDUE: begin
                // floored residue: a negative value with nonzero remainder maps to m - rem
                r_nr <= (r_neg && (i_div_rem != '0)) ? r_modulus - i_div_rem : i_div_rem;
                r_r  <= r_modulus;
                r_t  <= '0;
                r_nt <= TW'(1);
            end
            OP_MUL: begin
                r_prod <= w_q * r_nt;
                r_r    <= r_nr;
                r_nr   <= i_div_rem;
            end
            OP_TUPD: begin
                r_t  <= r_nt;
                r_nt <= r_t - r_prod;
            end
            OP_FIX: begin
                if (r_t < 0) begin
                    r_t <= r_t + w_m;
                end
            end
            OP_EMIT_OK: begin
                r_out_inverse <= r_t[MOD_W-1:0];
                r_out_flag    <= 1'b0;
            end
            OP_EMIT_FAIL: begin
                r_out_inverse <= '0;
                r_out_flag    <= 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.inverse    = r_out_inverse;
    assign o_out.no_inverse = r_out_flag;
endmodule

[rtl/core/mi_checker.sv]
// Port-level checks for the modular inverse top level, attached by bind.
// Depends on mi_pkg and modular_inverse_top_defines.svh.
`include "modular_inverse_top_defines.svh"

module mi_checker import mi_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [MOD_W-1:0] i_out_inverse,
    input logic             i_out_no_inverse
);
    // hold a result word until it is taken
    `MI_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    // a failed inversion always reads zero
    `MI_ASSERT_IMPL(a_fail_zero, i_clk, i_rst_n, i_out_valid && i_out_no_inverse, i_out_inverse == '0)
    // one word at a time: drop ready right after a word is taken
    `MI_ASSERT_NEXT(a_one_word, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)
    // a result never appears in the cycle after an input is taken
    `MI_ASSERT_NEXT(a_no_early, i_clk, i_rst_n, i_in_valid && i_in_ready && !i_out_valid, !i_out_valid)
endmodule

bind modular_inverse_top mi_checker u_mi_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_inverse    (o_out.inverse),
    .i_out_no_inverse (o_out.no_inverse)
);
